### src/b2da_pkg.sv
// Shared constants and types for the binary to decimal ASCII converter.
package b2da_pkg;

	localparam int IN_WIDTH    = 64;
	localparam int VALUE_WIDTH = 64;
	localparam int DIGITS      = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int BCD_W       = 4 * DIGITS;
	localparam int CHAR_W      = 6;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);
	localparam int DCNT_W      = $clog2(DIGITS + 1);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);

	typedef struct packed {
		logic load;
		logic dabble;
		logic dshift;
	} ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

endpackage

### src/b2da_core.sv
// Shift-and-add-3 conversion datapath with a digit shifter for readout.
module b2da_core
	import b2da_pkg::*;
(
	input  logic                   clk,
	input  ctrl_t                  ctrl,
	input  logic [VALUE_WIDTH-1:0] value_in,
	output logic [3:0]             top_digit
);

	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       adj;

	// Every BCD digit of five or more is corrected before the next doubling.
	always_comb begin
		logic [3:0] d;
		for (int i = 0; i < DIGITS; i++) begin
			d = bcd_q[4*i +: 4];
			adj[4*i +: 4] = (d >= 4'd5) ? 4'(d + 4'd3) : d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= value_in;
			bcd_q <= '0;
		end else if (ctrl.dabble) begin
			bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_WIDTH-1]};
		end else if (ctrl.dshift) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];

endmodule

### src/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter.
// A word is taken when start is high and busy is low. The value is converted one bit per cycle
// by a shift-and-add-3 unit, then the 20 BCD digit places are read out from the top, one per
// cycle, and busy stays high through both phases. Leading zeros are dropped, so from 1 to 20
// result words appear, most significant digit first, each for one cycle with strobe high;
// last_digit marks the final one. The receiver cannot stall and must take each word in the
// cycle it is shown.
module binary_to_decimal_ascii
	import b2da_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [IN_WIDTH-1:0] value,
	output logic [CHAR_W-1:0]   digit_char,
	output logic                last_digit,
	output logic                strobe
);

	state_t              state_q;
	logic [CNT_W-1:0]    bit_cnt_q;
	logic [DCNT_W-1:0]   dig_left_q;
	logic                lead_q;
	logic                strobe_q;
	logic                last_q;
	logic [CHAR_W-1:0]   char_q;
	ctrl_t               ctrl;
	logic [3:0]          top_digit;
	logic                accept;
	logic                final_place;
	logic                emit;

	assign accept      = start && (state_q == ST_IDLE);
	assign final_place = (dig_left_q == DCNT_W'(1));
	// Once a nonzero digit has been seen, every later place is printed.
	assign emit        = !lead_q || (top_digit != 4'd0) || final_place;

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: ctrl.load   = start;
			ST_CONV: ctrl.dabble = 1'b1;
			ST_OUT:  ctrl.dshift = 1'b1;
			default: ctrl = '0;
		endcase
	end

	b2da_core u_core (
		.clk       (clk),
		.ctrl      (ctrl),
		.value_in  (value[VALUE_WIDTH-1:0]),
		.top_digit (top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bit_cnt_q  <= '0;
			dig_left_q <= '0;
			lead_q     <= 1'b1;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_OUT) && emit;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_CONV;
						bit_cnt_q <= CNT_W'(VALUE_WIDTH - 1);
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - CNT_W'(1);
					if (bit_cnt_q == '0) begin
						state_q    <= ST_OUT;
						dig_left_q <= DCNT_W'(DIGITS);
						lead_q     <= 1'b1;
					end
				end
				ST_OUT: begin
					dig_left_q <= dig_left_q - DCNT_W'(1);
					if (emit) begin
						lead_q <= 1'b0;
					end
					if (final_place) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && emit) begin
			char_q <= ASCII_ZERO + CHAR_W'(top_digit);
			last_q <= final_place;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign strobe     = strobe_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (digit_char >= ASCII_ZERO && digit_char <= ASCII_NINE))
		else $error("digit character out of range");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not start a conversion");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_digit) |=> !strobe)
		else $error("result word after the last digit");

	a_strobe_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_digit) |=> strobe)
		else $error("run ended without a last digit");

endmodule

### bench/tb_top.sv
// Testbench for the binary to decimal ASCII converter: directed table, then random words.
module tb_top;
	import b2da_pkg::*;

	localparam int RANDOM_WORDS = 190;
	localparam int QUIET_WORDS  = 40;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 250000;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} digit_word_t;

	typedef struct {
		logic [IN_WIDTH-1:0] number;
		string               text;
	} directed_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [IN_WIDTH-1:0] value;
	logic [CHAR_W-1:0]   digit_char;
	logic                last_digit;
	logic                strobe;

	digit_word_t pending_digits[$];
	int          mismatch_count;
	int          cycle_count;

	// An empty text means the row is checked against the predictor.
	directed_row_t directed_rows[] = '{
		'{64'd0, "0"},
		'{64'd1, "1"},
		'{64'd9, "9"},
		'{64'd10, "10"},
		'{64'd99, "99"},
		'{64'd100, "100"},
		'{64'd1234567890, "1234567890"},
		'{64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615"},
		'{64'd10000000000000000000, "10000000000000000000"},
		'{64'd9999999999999999999, "9999999999999999999"},
		'{64'h8000_0000_0000_0000, "9223372036854775808"},
		'{64'hFFFF_FFFF_FFFF_FFFE, ""},
		'{64'hAAAA_AAAA_AAAA_AAAA, ""},
		'{64'h5555_5555_5555_5555, ""},
		'{64'h0000_0001_0000_0000, ""},
		'{64'h0000_0000_FFFF_FFFF, ""},
		'{64'h0123_4567_89AB_CDEF, ""},
		'{64'd255, ""},
		'{64'd1000000, ""},
		'{64'd0, ""}
	};

	binary_to_decimal_ascii i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.digit_char (digit_char),
		.last_digit (last_digit),
		.strobe     (strobe)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// Queues the decimal digits of a number, most significant first.
	function automatic void queue_decimal_text(input logic [IN_WIDTH-1:0] number);
		logic [CHAR_W-1:0] rev_digits[DIGITS];
		logic [63:0]       rest;
		int                n;
		rest = 64'(number);
		if (VALUE_WIDTH < 64)
			rest = rest & ((64'd1 << VALUE_WIDTH) - 64'd1);
		n = 0;
		do begin
			rev_digits[n] = ASCII_ZERO + CHAR_W'(rest % 64'd10);
			n++;
			rest = rest / 64'd10;
		end while (rest != 0 && n < DIGITS);
		for (int k = 0; k < n; k++)
			pending_digits.push_back('{ch: rev_digits[n-1-k], last: (k == n - 1)});
	endfunction

	function automatic void queue_typed_text(input string text);
		for (int k = 0; k < text.len(); k++)
			pending_digits.push_back('{ch: CHAR_W'(text[k]), last: (k == text.len() - 1)});
	endfunction

	// Sends one word; returns at the edge where it was taken.
	task automatic send_word(input logic [IN_WIDTH-1:0] number, input string text,
			input int gap, input bit wait_idle);
		if (wait_idle || gap > 0)
			start <= 1'b0;
		if (wait_idle) begin
			do @(posedge clk); while (busy);
		end
		repeat (gap) @(posedge clk);
		start <= 1'b1;
		value <= number;
		do @(posedge clk); while (busy);
		if (text.len() > 0)
			queue_typed_text(text);
		else
			queue_decimal_text(number);
	endtask

	function automatic logic [IN_WIDTH-1:0] random_number();
		logic [63:0] r;
		logic [63:0] p;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: r = r >> $urandom_range(0, 63);
			1: ;
			2: begin
				p = 64'd1;
				repeat ($urandom_range(0, 19)) p = p * 64'd10;
				r = p + 64'($urandom_range(0, 2)) - 64'd1;
			end
			default: r = 64'($urandom_range(0, 999));
		endcase
		return IN_WIDTH'(r);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("binary_to_decimal_ascii regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		digit_word_t exp_word;
		if (arst_n && strobe) begin
			if (pending_digits.size() == 0) begin
				report_mismatch($sformatf("digit %0d with no word outstanding", digit_char));
			end else begin
				exp_word = pending_digits.pop_front();
				if (digit_char !== exp_word.ch)
					report_mismatch($sformatf("digit_char %0d, expected %0d",
						digit_char, exp_word.ch));
				if (last_digit !== exp_word.last)
					report_mismatch($sformatf("last_digit %0b, expected %0b",
						last_digit, exp_word.last));
			end
		end
	end

	initial begin
		int calm_left;
		int gap;
		bit wait_idle;
		mismatch_count = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].number, directed_rows[i].text,
				($urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0,
				$urandom_range(0, 3) == 0);

		// Hold off until the block has emitted everything outstanding.
		start <= 1'b0;
		while (pending_digits.size() != 0) @(posedge clk);

		calm_left = 0;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			gap = 0;
			wait_idle = 1'b0;
			if (calm_left > 0) begin
				calm_left--;
			end else if ($urandom_range(0, 5) == 0) begin
				calm_left = $urandom_range(5, 12);
			end else if (i < RANDOM_WORDS - QUIET_WORDS) begin
				gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 15) : 0;
				wait_idle = ($urandom_range(0, 2) == 0);
			end
			send_word(random_number(), "", gap, wait_idle);
		end
		start <= 1'b0;

		while (pending_digits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("binary_to_decimal_ascii regression: pass");
		else
			$display("binary_to_decimal_ascii regression: fail");
		$finish;
	end

endmodule
